FILE: rtl/ocb_pkg.sv
// ----------------------------------------------------------------------------
// ocb_pkg: shared constants of the octree node builder
// Key layout, field widths and the prefix helper used by the builder and its
// divider.
// ----------------------------------------------------------------------------
package ocb_pkg;

    localparam int TREE_DEPTH = 10;
    localparam int LEVEL_BITS = 3;
    localparam int KEY_W      = 30;
    localparam int LVL_W      = 4;
    localparam int POS_W      = 32;
    localparam int MASS_IN_W  = 16;
    localparam int IDX_W      = 16;
    localparam int SUM_W      = 64;
    localparam int MASS_W     = 32;
    localparam int COUNT_W    = 17;
    localparam int LIMIT_W    = 8;

    localparam logic [LVL_W-1:0]   LVL_LAST  = LVL_W'(TREE_DEPTH - 1);
    localparam logic [LVL_W-1:0]   LVL_NONE  = LVL_W'(TREE_DEPTH);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(8);

    // Key prefix of a level, level 0 is the coarsest.
    function automatic logic [KEY_W-1:0] prefix_at(input logic [KEY_W-1:0] key,
                                                    input logic [LVL_W-1:0] lvl);
        logic [LVL_W-1:0] up;
        up = LVL_LAST - lvl;
        return key >> (LEVEL_BITS * int'(up));
    endfunction

endpackage

FILE: rtl/ocb_div.sv
// ----------------------------------------------------------------------------
// ocb_div: iterative unsigned divider
// Restoring division of a 64-bit magnitude by a 32-bit mass, one quotient bit
// per cycle; done pulses high for a single cycle once the last bit is shifted in.
// ----------------------------------------------------------------------------
module ocb_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ocb_pkg::SUM_W-1:0]   i_dividend,
    input  logic [ocb_pkg::MASS_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [ocb_pkg::SUM_W-1:0]   o_quot
);

    logic                       r_busy;
    logic                       r_done;
    logic [5:0]                 r_cnt;
    logic [ocb_pkg::MASS_W-1:0] r_rem;
    logic [ocb_pkg::MASS_W-1:0] r_div;
    logic [ocb_pkg::SUM_W-1:0]  r_quot;
    logic [ocb_pkg::MASS_W:0]   n_trial;
    logic [ocb_pkg::MASS_W:0]   n_diff;
    logic                       n_bit;

    always_comb begin
        n_trial = {r_rem, r_quot[ocb_pkg::SUM_W-1]};
        n_diff  = n_trial - {1'b0, r_div};
        n_bit   = !n_diff[ocb_pkg::MASS_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '1;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_quot <= i_dividend;
        end else if (r_busy) begin
            // keep the partial remainder when the trial goes negative
            r_rem  <= n_bit ? n_diff[ocb_pkg::MASS_W-1:0] : n_trial[ocb_pkg::MASS_W-1:0];
            r_quot <= {r_quot[ocb_pkg::SUM_W-2:0], n_bit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

FILE: rtl/octree_node_builder.sv
// ----------------------------------------------------------------------------
// octree_node_builder: octree node stack over key-sorted particles
// Keeps one open node per level and emits closed nodes with their centers.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests carry one particle each (key, position, mass, index,
//   set_end) and are taken when i_valid is high and o_stall is low. o_stall
//   stays high while a particle is being worked on.
//   Output requests carry one closed node each, deepest first; run_last marks
//   the last node caused by a particle and tree_end the root of a flush.
//   Per particle: position-mass products for x, y and z, a prefix compare of
//   up to 10 levels, a stack update of every level, and for each emitted node
//   3 divisions in the shared bit-serial divider, with a restart state before
//   each later division or node, plus a load of the output register.
//   The output register frees the builder: the next particle is taken while
//   the last node still waits. While i_stall holds, the node waits in place
//   and the builder holds before loading the next one.
//   Reset clears the stack (no particle seen) and sets leaf_limit to 8.
//   i_cfg_we writes leaf_limit; write it only while the block is idle.
// ----------------------------------------------------------------------------
module octree_node_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [29:0] i_particle_key,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic [15:0] i_particle_mass,
    input  logic [15:0] i_particle_index,
    input  logic        i_set_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [29:0] o_node_prefix,
    output logic [3:0]  o_node_level,
    output logic signed [31:0] o_center_x,
    output logic signed [31:0] o_center_y,
    output logic signed [31:0] o_center_z,
    output logic [31:0] o_total_mass,
    output logic [16:0] o_particle_count,
    output logic [15:0] o_start_index,
    output logic        o_is_leaf,
    output logic        o_tree_end,
    output logic        o_run_last
);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_SCAN, S_DIV, S_DIVW, S_EMIT, S_UPD, S_ENDSCAN
    } t_state;

    localparam int D = ocb_pkg::TREE_DEPTH;

    // node stack
    logic [ocb_pkg::KEY_W-1:0]   r_keys  [D];
    logic [ocb_pkg::SUM_W-1:0]   r_sx    [D];
    logic [ocb_pkg::SUM_W-1:0]   r_sy    [D];
    logic [ocb_pkg::SUM_W-1:0]   r_sz    [D];
    logic [ocb_pkg::MASS_W-1:0]  r_mass  [D];
    logic [ocb_pkg::COUNT_W-1:0] r_cnt   [D];
    logic [ocb_pkg::IDX_W-1:0]   r_start [D];

    t_state                        r_state;
    logic                          r_stack_valid;
    logic [ocb_pkg::LIMIT_W-1:0]   r_limit;
    logic [ocb_pkg::KEY_W-1:0]     r_key;
    logic signed [31:0]            r_x, r_y, r_z;
    logic [ocb_pkg::MASS_IN_W-1:0] r_m;
    logic [ocb_pkg::IDX_W-1:0]     r_idx;
    logic                          r_end;
    logic [ocb_pkg::SUM_W-1:0]     r_px, r_py, r_pz;
    logic [1:0]                    r_ax;
    logic [ocb_pkg::LVL_W-1:0]     r_lv;
    logic [ocb_pkg::LVL_W-1:0]     r_lo;
    logic                          r_found;
    logic                          r_phase;
    logic                          r_neg;
    logic                          r_div_start;
    logic [31:0]                   r_cx, r_cy, r_cz;

    logic                          r_o_valid;
    logic [29:0]                   r_o_key;
    logic [3:0]                    r_o_level;
    logic [31:0]                   r_o_cx, r_o_cy, r_o_cz;
    logic [31:0]                   r_o_mass;
    logic [16:0]                   r_o_count;
    logic [15:0]                   r_o_start;
    logic                          r_o_leaf, r_o_tend, r_o_last;

    logic                          n_accept;
    logic                          n_out_free;
    logic signed [31:0]            n_mul_a;
    logic signed [48:0]            n_prod;
    logic                          n_mismatch;
    logic                          n_small;
    logic [ocb_pkg::SUM_W-1:0]     n_sum;
    logic [ocb_pkg::SUM_W-1:0]     n_mag;
    logic                          div_done;
    logic [ocb_pkg::SUM_W-1:0]     div_quot;
    logic [31:0]                   n_center;
    logic [ocb_pkg::MASS_W:0]      n_mass_add;

    assign n_accept   = i_valid && !o_stall;
    assign n_out_free = !r_o_valid || !i_stall;

    always_comb begin
        unique case (r_ax)
            2'd0:    n_mul_a = r_x;
            2'd1:    n_mul_a = r_y;
            default: n_mul_a = r_z;
        endcase
        n_prod = n_mul_a * $signed({1'b0, r_m});

        n_mismatch = ocb_pkg::prefix_at(r_key, r_lv) != r_keys[r_lv];
        n_small    = r_cnt[r_lv] <= ocb_pkg::COUNT_W'(r_limit);

        unique case (r_ax)
            2'd0:    n_sum = r_sx[r_lv];
            2'd1:    n_sum = r_sy[r_lv];
            default: n_sum = r_sz[r_lv];
        endcase
        n_mag = n_sum[ocb_pkg::SUM_W-1] ? (~n_sum + 1'b1) : n_sum;

        // truncated quotient, saturated to the signed 32-bit range
        if (r_mass[r_lv] == '0) begin
            n_center = '0;
        end else if (!r_neg) begin
            n_center = (div_quot > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_quot[31:0];
        end else if (div_quot > 64'h8000_0000) begin
            n_center = 32'h8000_0000;
        end else begin
            n_center = ~div_quot[31:0] + 1'b1;
        end

        n_mass_add = {1'b0, r_mass[r_lv]} + ocb_pkg::MASS_W'(r_m);
    end

    ocb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (n_mag),
        .i_divisor  (r_mass[r_lv]),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // stack update, one level per cycle
    always_ff @(posedge i_clk) begin
        if (r_state == S_UPD) begin
            if (!r_stack_valid || r_lv >= r_lo) begin
                r_keys[r_lv]  <= ocb_pkg::prefix_at(r_key, r_lv);
                r_sx[r_lv]    <= r_px;
                r_sy[r_lv]    <= r_py;
                r_sz[r_lv]    <= r_pz;
                r_mass[r_lv]  <= ocb_pkg::MASS_W'(r_m);
                r_cnt[r_lv]   <= ocb_pkg::COUNT_W'(1);
                r_start[r_lv] <= r_idx;
            end else begin
                r_sx[r_lv]   <= r_sx[r_lv] + r_px;
                r_sy[r_lv]   <= r_sy[r_lv] + r_py;
                r_sz[r_lv]   <= r_sz[r_lv] + r_pz;
                r_mass[r_lv] <= n_mass_add[ocb_pkg::MASS_W] ? '1
                                : n_mass_add[ocb_pkg::MASS_W-1:0];
                if (r_cnt[r_lv] != ocb_pkg::COUNT_MAX) begin
                    r_cnt[r_lv] <= r_cnt[r_lv] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_key <= i_particle_key;
            r_x   <= i_pos_x;
            r_y   <= i_pos_y;
            r_z   <= i_pos_z;
            r_m   <= i_particle_mass;
            r_idx <= i_particle_index;
            r_end <= i_set_end;
        end
        if (r_state == S_MUL) begin
            unique case (r_ax)
                2'd0:    r_px <= ocb_pkg::SUM_W'(n_prod);
                2'd1:    r_py <= ocb_pkg::SUM_W'(n_prod);
                default: r_pz <= ocb_pkg::SUM_W'(n_prod);
            endcase
        end
        if (r_div_start) begin
            r_neg <= n_sum[ocb_pkg::SUM_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_stack_valid <= 1'b0;
            r_limit       <= ocb_pkg::LIMIT_RST;
            r_o_valid     <= 1'b0;
            r_div_start   <= 1'b0;
            r_ax          <= '0;
            r_lv          <= '0;
            r_lo          <= '0;
            r_found       <= 1'b0;
            r_phase       <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_ax    <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_ax <= r_ax + 2'd1;
                    if (r_ax == 2'd2) begin
                        r_lv    <= '0;
                        r_found <= 1'b0;
                        r_lo    <= '0;
                        r_state <= r_stack_valid ? S_SCAN : S_UPD;
                    end
                end
                S_SCAN: begin
                    // find the first changed level and the last one to emit
                    if (!r_found && !n_mismatch) begin
                        if (r_lv == ocb_pkg::LVL_LAST) begin
                            r_lo    <= ocb_pkg::LVL_NONE;
                            r_lv    <= '0;
                            r_state <= S_UPD;
                        end else begin
                            r_lv <= r_lv + 1'b1;
                        end
                    end else begin
                        if (!r_found) begin
                            r_lo    <= r_lv;
                            r_found <= 1'b1;
                        end
                        if (n_small || r_lv == ocb_pkg::LVL_LAST) begin
                            r_phase     <= 1'b0;
                            r_ax        <= '0;
                            r_div_start <= 1'b1;
                            r_state     <= S_DIVW;
                        end else begin
                            r_lv <= r_lv + 1'b1;
                        end
                    end
                end
                S_DIV: begin
                    r_div_start <= 1'b1;
                    r_state     <= S_DIVW;
                end
                S_DIVW: begin
                    if (div_done) begin
                        r_ax <= r_ax + 2'd1;
                        unique case (r_ax)
                            2'd0:    r_cx <= n_center;
                            2'd1:    r_cy <= n_center;
                            default: r_cz <= n_center;
                        endcase
                        r_state <= (r_ax == 2'd2) ? S_EMIT : S_DIV;
                    end
                end
                S_EMIT: begin
                    if (n_out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_key   <= r_keys[r_lv];
                        r_o_level <= r_lv + 1'b1;
                        r_o_cx    <= r_cx;
                        r_o_cy    <= r_cy;
                        r_o_cz    <= r_cz;
                        r_o_mass  <= r_mass[r_lv];
                        r_o_count <= r_cnt[r_lv];
                        r_o_start <= r_start[r_lv];
                        r_o_leaf  <= n_small || r_lv == ocb_pkg::LVL_LAST;
                        r_o_tend  <= r_phase && r_lv == '0;
                        r_o_last  <= (r_lv == r_lo) && (r_phase || !r_end);
                        r_ax      <= '0;
                        if (r_lv == r_lo) begin
                            if (r_phase) begin
                                r_stack_valid <= 1'b0;
                                r_state       <= S_IDLE;
                            end else begin
                                r_lv    <= '0;
                                r_state <= S_UPD;
                            end
                        end else begin
                            r_lv    <= r_lv - 1'b1;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_UPD: begin
                    if (r_lv == ocb_pkg::LVL_LAST) begin
                        r_stack_valid <= 1'b1;
                        r_lv          <= '0;
                        r_state       <= r_end ? S_ENDSCAN : S_IDLE;
                    end else begin
                        r_lv <= r_lv + 1'b1;
                    end
                end
                S_ENDSCAN: begin
                    // flush: emit from the first small level up to the root
                    if (n_small || r_lv == ocb_pkg::LVL_LAST) begin
                        r_lo        <= '0;
                        r_phase     <= 1'b1;
                        r_ax        <= '0;
                        r_div_start <= 1'b1;
                        r_state     <= S_DIVW;
                    end else begin
                        r_lv <= r_lv + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall          = r_state != S_IDLE;
    assign o_valid          = r_o_valid;
    assign o_node_prefix    = r_o_key;
    assign o_node_level     = r_o_level;
    assign o_center_x       = r_o_cx;
    assign o_center_y       = r_o_cy;
    assign o_center_z       = r_o_cz;
    assign o_total_mass     = r_o_mass;
    assign o_particle_count = r_o_count;
    assign o_start_index    = r_o_start;
    assign o_is_leaf        = r_o_leaf;
    assign o_tree_end       = r_o_tend;
    assign o_run_last       = r_o_last;

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIVW)
        else $error("divider finished outside its wait state");

    a_tend_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_tend |-> r_o_last)
        else $error("tree end node not marked last");

    a_scan_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_stack_valid)
        else $error("prefix compare on an empty stack");

    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT && r_o_valid && i_stall |=> r_state == S_EMIT)
        else $error("node emitted over a stalled one");

endmodule
